[src/c8alu_pkg.sv]
// ----------------------------------------------------------------------------
// c8alu_pkg
// Shared types, operation codes and flag positions of the 8-bit execute stage.
// ----------------------------------------------------------------------------
package c8alu_pkg;

  // operation codes, alphabetical by mnemonic
  typedef enum logic [5:0] {
    OP_ADC   = 6'd0,  OP_AND   = 6'd1,  OP_ASL_A = 6'd2,  OP_ASL_M = 6'd3,
    OP_BCC   = 6'd4,  OP_BCS   = 6'd5,  OP_BEQ   = 6'd6,  OP_BIT   = 6'd7,
    OP_BMI   = 6'd8,  OP_BNE   = 6'd9,  OP_BPL   = 6'd10, OP_BVC   = 6'd11,
    OP_BVS   = 6'd12, OP_CLC   = 6'd13, OP_CLD   = 6'd14, OP_CLI   = 6'd15,
    OP_CLV   = 6'd16, OP_CMP   = 6'd17, OP_CPX   = 6'd18, OP_CPY   = 6'd19,
    OP_DEC   = 6'd20, OP_DEX   = 6'd21, OP_DEY   = 6'd22, OP_EOR   = 6'd23,
    OP_INC   = 6'd24, OP_INX   = 6'd25, OP_INY   = 6'd26, OP_LDA   = 6'd27,
    OP_LDX   = 6'd28, OP_LDY   = 6'd29, OP_LSR_A = 6'd30, OP_LSR_M = 6'd31,
    OP_NOP   = 6'd32, OP_ORA   = 6'd33, OP_PHA   = 6'd34, OP_PHP   = 6'd35,
    OP_PLA   = 6'd36, OP_PLP   = 6'd37, OP_ROL_A = 6'd38, OP_ROL_M = 6'd39,
    OP_ROR_A = 6'd40, OP_ROR_M = 6'd41, OP_SBC   = 6'd42, OP_SEC   = 6'd43,
    OP_SED   = 6'd44, OP_SEI   = 6'd45, OP_STA   = 6'd46, OP_STX   = 6'd47,
    OP_STY   = 6'd48, OP_TAX   = 6'd49, OP_TAY   = 6'd50, OP_TSX   = 6'd51,
    OP_TXA   = 6'd52, OP_TXS   = 6'd53, OP_TYA   = 6'd54
  } op_t;

  // status bit positions, NV-BDIZC
  localparam int FLG_C = 0;
  localparam int FLG_Z = 1;
  localparam int FLG_I = 2;
  localparam int FLG_D = 3;
  localparam int FLG_B = 4;
  localparam int FLG_U = 5;
  localparam int FLG_V = 6;
  localparam int FLG_N = 7;

  localparam logic [7:0] FLAGS_BU = 8'h30;
  localparam logic [7:0] SP_RESET = 8'hFD;

  typedef struct packed {
    logic [5:0]  mode;
    logic [7:0]  operand;
    logic [15:0] pc_now;
  } item_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } arch_t;

  typedef struct packed {
    logic        taken;
    logic [15:0] target;
    logic        crossed;
  } branch_t;

  typedef struct packed {
    logic [7:0]  write_data;
    logic        write_enable;
    logic [8:0]  stack_address;
    branch_t     br;
  } res_t;

endpackage

[src/cpu8bit_register_alu_execute.sv]
// ----------------------------------------------------------------------------
// cpu8bit_register_alu_execute
// Execute stage of a 6502-style CPU, binary arithmetic only. Each item names
// one operation (ALU, shift/rotate, inc/dec, load, store, transfer, flag,
// push/pull, branch), carries the already fetched operand byte and the pc
// after the operand fetch, and yields one result item with the byte to
// write, the stack address, the branch decision, target and page crossing,
// and A, X, Y, P, SP after the operation. The item is captured in an input
// register, executed in combinational logic against the architectural
// registers, and lands in an output register. One item is taken every
// cycle as long as results are drained, since each operation is a single
// 8-bit add or logic step. A stalled output still lets one more item be
// captured in the input register. Reset sets SP to 0xFD and all other
// architectural registers to 0; the decimal flag is stored but never
// alters arithmetic, and unused codes 55 to 63 behave as NOP.
// ----------------------------------------------------------------------------
module cpu8bit_register_alu_execute (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  mode,
  input  logic [7:0]  operand,
  input  logic [15:0] pc_now,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  write_data,
  output logic        write_enable,
  output logic [8:0]  stack_address,
  output logic        branch_taken,
  output logic [15:0] branch_target,
  output logic        page_crossed,
  output logic [7:0]  acc_out,
  output logic [7:0]  x_out,
  output logic [7:0]  y_out,
  output logic [7:0]  status_out,
  output logic [7:0]  sp_out
);

  // input register
  logic              s1_valid;
  c8alu_pkg::item_t  s1_item;

  // architectural state
  c8alu_pkg::arch_t  arch;
  c8alu_pkg::arch_t  arch_next;
  c8alu_pkg::res_t   res;

  // output register
  c8alu_pkg::res_t   out_res;
  c8alu_pkg::arch_t  out_arch;

  logic advance;
  logic commit;

  // output register is free, or drains this cycle
  assign advance  = ~out_valid | out_ready;
  // item in the input register executes and updates state
  assign commit   = s1_valid & advance;
  assign in_ready = ~s1_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.mode    <= mode;
      s1_item.operand <= operand;
      s1_item.pc_now  <= pc_now;
    end
  end

  c8alu_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .commit    (commit),
    .arch_next (arch_next),
    .arch      (arch)
  );

  c8alu_exec u_exec (
    .item      (s1_item),
    .arch      (arch),
    .arch_next (arch_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res  <= res;
      out_arch <= arch_next;
    end
  end

  assign write_data    = out_res.write_data;
  assign write_enable  = out_res.write_enable;
  assign stack_address = out_res.stack_address;
  assign branch_taken  = out_res.br.taken;
  assign branch_target = out_res.br.target;
  assign page_crossed  = out_res.br.crossed;
  assign acc_out       = out_arch.acc;
  assign x_out         = out_arch.x;
  assign y_out         = out_arch.y;
  assign status_out    = out_arch.p;
  assign sp_out        = out_arch.sp;

`ifndef SYNTHESIS
  // registers move only when an item executes
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(arch))
    else $error("architectural state changed without an executing item");

  // reported registers match the live state once a result is shown
  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    commit |=> (out_arch == arch))
    else $error("result registers differ from architectural state");

  a_no_write_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (write_data == 8'd0))
    else $error("write data nonzero without write enable");

  a_cross_needs_taken: assert property (@(posedge clk) disable iff (rst)
    (out_valid && page_crossed) |-> branch_taken)
    else $error("page crossing flagged on a branch not taken");

  a_stack_page: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stack_address[8])
    else $error("stack address outside the stack page");
`endif

endmodule

[src/c8alu_branch.sv]
// ----------------------------------------------------------------------------
// c8alu_branch
// Branch condition test, relative target add and page crossing check.
// ----------------------------------------------------------------------------
module c8alu_branch (
  input  c8alu_pkg::op_t     op,
  input  logic [7:0]         operand,
  input  logic [15:0]        pc_now,
  input  logic [7:0]         p,
  output c8alu_pkg::branch_t br
);

  logic        is_branch;
  logic        cond;
  logic [15:0] target;

  always_comb begin
    is_branch = 1'b1;
    cond      = 1'b0;
    unique case (op)
      c8alu_pkg::OP_BCC: cond = ~p[c8alu_pkg::FLG_C];
      c8alu_pkg::OP_BCS: cond =  p[c8alu_pkg::FLG_C];
      c8alu_pkg::OP_BEQ: cond =  p[c8alu_pkg::FLG_Z];
      c8alu_pkg::OP_BNE: cond = ~p[c8alu_pkg::FLG_Z];
      c8alu_pkg::OP_BMI: cond =  p[c8alu_pkg::FLG_N];
      c8alu_pkg::OP_BPL: cond = ~p[c8alu_pkg::FLG_N];
      c8alu_pkg::OP_BVS: cond =  p[c8alu_pkg::FLG_V];
      c8alu_pkg::OP_BVC: cond = ~p[c8alu_pkg::FLG_V];
      default:           is_branch = 1'b0;
    endcase
  end

  // sign-extended offset, wraps at 64k
  assign target = pc_now + {{8{operand[7]}}, operand};

  assign br.taken   = is_branch & cond;
  assign br.target  = is_branch ? target : 16'd0;
  assign br.crossed = is_branch & cond & (target[15:8] != pc_now[15:8]);

endmodule

[src/c8alu_exec.sv]
// ----------------------------------------------------------------------------
// c8alu_exec
// Combinational datapath: ALU, shifter, compare, stack and transfer logic.
// ----------------------------------------------------------------------------
module c8alu_exec (
  input  c8alu_pkg::item_t item,
  input  c8alu_pkg::arch_t arch,
  output c8alu_pkg::arch_t arch_next,
  output c8alu_pkg::res_t  res
);

  c8alu_pkg::op_t     op;
  logic [7:0]         m;
  logic [7:0]         m_eff;
  logic [8:0]         sum;
  logic [7:0]         cmp_reg;
  logic [8:0]         diff;
  logic [7:0]         shift_src;
  logic               shift_cin;
  logic [7:0]         shl;
  logic [7:0]         shr;
  logic               is_push;
  c8alu_pkg::branch_t br;

  assign op = c8alu_pkg::op_t'(item.mode);
  assign m  = item.operand;

  // shared adder, subtract by adding the complement
  assign m_eff = (op == c8alu_pkg::OP_SBC) ? ~m : m;
  assign sum   = {1'b0, arch.acc} + {1'b0, m_eff} + {8'd0, arch.p[c8alu_pkg::FLG_C]};

  // shared comparator
  assign cmp_reg = (op == c8alu_pkg::OP_CPX) ? arch.x :
                   (op == c8alu_pkg::OP_CPY) ? arch.y : arch.acc;
  assign diff    = {1'b0, cmp_reg} - {1'b0, m};

  // shared shifter, memory forms take the operand
  assign shift_src = (op == c8alu_pkg::OP_ASL_M || op == c8alu_pkg::OP_LSR_M ||
                      op == c8alu_pkg::OP_ROL_M || op == c8alu_pkg::OP_ROR_M) ?
                     m : arch.acc;
  assign shift_cin = arch.p[c8alu_pkg::FLG_C] &
                     (op == c8alu_pkg::OP_ROL_A || op == c8alu_pkg::OP_ROL_M ||
                      op == c8alu_pkg::OP_ROR_A || op == c8alu_pkg::OP_ROR_M);
  assign shl = {shift_src[6:0], shift_cin};
  assign shr = {shift_cin, shift_src[7:1]};

  assign is_push = (op == c8alu_pkg::OP_PHA) || (op == c8alu_pkg::OP_PHP);

  c8alu_branch u_branch (
    .op      (op),
    .operand (m),
    .pc_now  (item.pc_now),
    .p       (arch.p),
    .br      (br)
  );

  always_comb begin
    logic [7:0] nz_val;
    logic       nz_en;
    logic [7:0] wdata;
    logic       we;

    arch_next = arch;
    nz_val    = 8'd0;
    nz_en     = 1'b0;
    wdata     = 8'd0;
    we        = 1'b0;

    unique case (op)
      c8alu_pkg::OP_ADC, c8alu_pkg::OP_SBC: begin
        arch_next.acc = sum[7:0];
        arch_next.p[c8alu_pkg::FLG_C] = sum[8];
        arch_next.p[c8alu_pkg::FLG_V] = ~(arch.acc[7] ^ m_eff[7]) & (arch.acc[7] ^ sum[7]);
        nz_val = sum[7:0];
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_AND: begin
        arch_next.acc = arch.acc & m;
        nz_val = arch.acc & m;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_ORA: begin
        arch_next.acc = arch.acc | m;
        nz_val = arch.acc | m;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_EOR: begin
        arch_next.acc = arch.acc ^ m;
        nz_val = arch.acc ^ m;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_ASL_A, c8alu_pkg::OP_ROL_A: begin
        arch_next.acc = shl;
        arch_next.p[c8alu_pkg::FLG_C] = shift_src[7];
        nz_val = shl;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_ASL_M, c8alu_pkg::OP_ROL_M: begin
        arch_next.p[c8alu_pkg::FLG_C] = shift_src[7];
        wdata  = shl;
        we     = 1'b1;
        nz_val = shl;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_LSR_A, c8alu_pkg::OP_ROR_A: begin
        arch_next.acc = shr;
        arch_next.p[c8alu_pkg::FLG_C] = shift_src[0];
        nz_val = shr;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_LSR_M, c8alu_pkg::OP_ROR_M: begin
        arch_next.p[c8alu_pkg::FLG_C] = shift_src[0];
        wdata  = shr;
        we     = 1'b1;
        nz_val = shr;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_BIT: begin
        arch_next.p[c8alu_pkg::FLG_Z] = ((arch.acc & m) == 8'd0);
        arch_next.p[c8alu_pkg::FLG_N] = m[7];
        arch_next.p[c8alu_pkg::FLG_V] = m[6];
      end
      c8alu_pkg::OP_CLC: arch_next.p[c8alu_pkg::FLG_C] = 1'b0;
      c8alu_pkg::OP_CLD: arch_next.p[c8alu_pkg::FLG_D] = 1'b0;
      c8alu_pkg::OP_CLI: arch_next.p[c8alu_pkg::FLG_I] = 1'b0;
      c8alu_pkg::OP_CLV: arch_next.p[c8alu_pkg::FLG_V] = 1'b0;
      c8alu_pkg::OP_SEC: arch_next.p[c8alu_pkg::FLG_C] = 1'b1;
      c8alu_pkg::OP_SED: arch_next.p[c8alu_pkg::FLG_D] = 1'b1;
      c8alu_pkg::OP_SEI: arch_next.p[c8alu_pkg::FLG_I] = 1'b1;
      c8alu_pkg::OP_CMP, c8alu_pkg::OP_CPX, c8alu_pkg::OP_CPY: begin
        arch_next.p[c8alu_pkg::FLG_C] = ~diff[8];
        nz_val = diff[7:0];
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_DEC: begin
        wdata  = m - 8'd1;
        we     = 1'b1;
        nz_val = m - 8'd1;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_INC: begin
        wdata  = m + 8'd1;
        we     = 1'b1;
        nz_val = m + 8'd1;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_DEX: begin
        arch_next.x = arch.x - 8'd1;
        nz_val = arch.x - 8'd1;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_DEY: begin
        arch_next.y = arch.y - 8'd1;
        nz_val = arch.y - 8'd1;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_INX: begin
        arch_next.x = arch.x + 8'd1;
        nz_val = arch.x + 8'd1;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_INY: begin
        arch_next.y = arch.y + 8'd1;
        nz_val = arch.y + 8'd1;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_LDA, c8alu_pkg::OP_PLA: begin
        arch_next.acc = m;
        nz_val = m;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_LDX: begin
        arch_next.x = m;
        nz_val = m;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_LDY: begin
        arch_next.y = m;
        nz_val = m;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_PLP: arch_next.p = m & ~c8alu_pkg::FLAGS_BU;
      c8alu_pkg::OP_PHA: begin
        wdata = arch.acc;
        we    = 1'b1;
      end
      c8alu_pkg::OP_PHP: begin
        wdata = arch.p | c8alu_pkg::FLAGS_BU;
        we    = 1'b1;
      end
      c8alu_pkg::OP_STA: begin
        wdata = arch.acc;
        we    = 1'b1;
      end
      c8alu_pkg::OP_STX: begin
        wdata = arch.x;
        we    = 1'b1;
      end
      c8alu_pkg::OP_STY: begin
        wdata = arch.y;
        we    = 1'b1;
      end
      c8alu_pkg::OP_TAX: begin
        arch_next.x = arch.acc;
        nz_val = arch.acc;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_TAY: begin
        arch_next.y = arch.acc;
        nz_val = arch.acc;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_TSX: begin
        arch_next.x = arch.sp;
        nz_val = arch.sp;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_TXA: begin
        arch_next.acc = arch.x;
        nz_val = arch.x;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_TYA: begin
        arch_next.acc = arch.y;
        nz_val = arch.y;
        nz_en  = 1'b1;
      end
      c8alu_pkg::OP_TXS: arch_next.sp = arch.x;
      // branches, nop and unused codes leave registers alone
      default: ;
    endcase

    // stack pointer moves for push and pull
    if (is_push) begin
      arch_next.sp = arch.sp - 8'd1;
    end else if (op == c8alu_pkg::OP_PLA || op == c8alu_pkg::OP_PLP) begin
      arch_next.sp = arch.sp + 8'd1;
    end

    if (nz_en) begin
      arch_next.p[c8alu_pkg::FLG_N] = nz_val[7];
      arch_next.p[c8alu_pkg::FLG_Z] = (nz_val == 8'd0);
    end

    res.write_data   = wdata;
    res.write_enable = we;
    // push addresses the old pointer, everything else the new one
    res.stack_address = {1'b1, (is_push ? arch.sp : arch_next.sp)};
    res.br           = br;
  end

endmodule

[src/c8alu_regs.sv]
// ----------------------------------------------------------------------------
// c8alu_regs
// Architectural registers A, X, Y, SP and P with reset values.
// ----------------------------------------------------------------------------
module c8alu_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             commit,
  input  c8alu_pkg::arch_t arch_next,
  output c8alu_pkg::arch_t arch
);

  always_ff @(posedge clk) begin
    if (rst) begin
      arch.acc <= 8'd0;
      arch.x   <= 8'd0;
      arch.y   <= 8'd0;
      arch.sp  <= c8alu_pkg::SP_RESET;
      arch.p   <= 8'd0;
    end else if (commit) begin
      arch <= arch_next;
    end
  end

endmodule
